// ===== sv/prt_pkg.sv =====
// Shared types, constants and a helper function for the profile table resolver.
`default_nettype none

package prt_pkg;

    // Default number of profile slots.
    localparam int SLOT_COUNT_DEF = 64;

    // Field widths.
    localparam int ID_W   = 16;
    localparam int CAP_W  = 8;
    localparam int TRIG_W = 18;
    localparam int CAPO_W = 3;

    // Configuration register indexes.
    localparam logic [1:0] REG_FB_BIT_CAP   = 2'd0;
    localparam logic [1:0] REG_FB_DOWNGRADE = 2'd1;
    localparam logic [1:0] REG_FB_COMPRESS  = 2'd2;

    // Command codes; the last one is unassigned and only yields an all-zero result.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Reset values of the fallback registers.
    localparam logic [CAP_W-1:0]  FB_BIT_CAP_RST   = 8'd4;
    localparam logic [TRIG_W-1:0] FB_DOWNGRADE_RST = 18'd0;
    localparam logic [TRIG_W-1:0] FB_COMPRESS_RST  = 18'd49152;

    // Q2.16 constants: 0.05 rounded to nearest, and 0.5.
    localparam logic [TRIG_W-1:0] Q_FIVE_HUNDREDTHS = 18'd3277;
    localparam logic [TRIG_W-1:0] Q_HALF            = 18'd32768;
    localparam logic [TRIG_W-1:0] Q_HEAVY_LIMIT     = 18'd36045;

    // Bit cap clamp limits.
    localparam logic [CAP_W-1:0] CAP_MIN = 8'd2;
    localparam logic [CAP_W-1:0] CAP_MAX = 8'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } prt_state_t;

    // One stored profile.
    typedef struct packed {
        logic [ID_W-1:0]   prof_key;
        logic [CAP_W-1:0]  bit_cap;
        logic [TRIG_W-1:0] downgrade_trigger;
        logic [TRIG_W-1:0] compress_trigger;
        logic              storage_heavy;
    } prt_profile_t;

    // One input item; the last member sits in the lowest bits.
    typedef struct packed {
        logic [TRIG_W-1:0] pressure;
        logic              storage_heavy;
        logic [TRIG_W-1:0] compress_trigger;
        logic [TRIG_W-1:0] downgrade_trigger;
        logic [CAP_W-1:0]  bit_cap;
        logic [ID_W-1:0]   prof_key;
        logic [1:0]        command;
    } prt_item_t;

    // One result item; the last member sits in the lowest bits.
    typedef struct packed {
        logic              compress_kv;
        logic [TRIG_W-1:0] downgrade_trigger_out;
        logic [CAPO_W-1:0] bit_cap_out;
        logic              stored;
        logic              found;
    } prt_result_t;

    // Outcome of one table scan, handed from the sequencer to the resolver.
    typedef struct packed {
        logic [1:0]        command;
        logic              hit;
        logic              free_found;
        logic [TRIG_W-1:0] pressure;
        prt_profile_t      prof;
    } prt_scan_t;

    localparam int ITEM_W   = $bits(prt_item_t);
    localparam int RESULT_W = $bits(prt_result_t);
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Clamp a raw bit cap to the range two through four.
    function automatic logic [CAPO_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
        logic [CAPO_W-1:0] r;
        if (c < CAP_MIN) begin
            r = CAPO_W'(CAP_MIN);
        end else if (c > CAP_MAX) begin
            r = CAPO_W'(CAP_MAX);
        end else begin
            r = c[CAPO_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/prt_store.sv =====
// Profile memory: one write port and one registered read port.
`default_nettype none

module prt_store #(
    parameter int SLOT_COUNT = prt_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_addr,
    input  wire prt_pkg::prt_profile_t wr_data,
    input  wire logic [IDX_W-1:0]      rd_addr,
    output prt_pkg::prt_profile_t      rd_data
);

    prt_pkg::prt_profile_t mem [SLOT_COUNT];
    prt_pkg::prt_profile_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/prt_ctrl.sv =====
// Scan sequencer: slot valid bits, shared key comparator and the upsert write.
`default_nettype none

module prt_ctrl #(
    parameter int SLOT_COUNT = prt_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire prt_pkg::prt_item_t    in_item,
    input  wire logic                  out_free,
    output logic                       res_load,
    output prt_pkg::prt_scan_t         scan_res,
    output logic [IDX_W-1:0]           rd_addr,
    input  wire prt_pkg::prt_profile_t rd_data,
    output logic                       wr_en,
    output logic [IDX_W-1:0]           wr_addr,
    output prt_pkg::prt_profile_t      wr_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    prt_pkg::prt_state_t   state_reg, state_next;
    prt_pkg::prt_item_t    item_reg, item_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  cmp_vbit_reg, cmp_vbit_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    prt_pkg::prt_profile_t hit_prof_reg, hit_prof_next;
    logic                  free_reg, free_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic                  key_match;
    logic                  slot_empty;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= prt_pkg::ST_IDLE;
            valid_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
        end
    end

    // Payload state.
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        cmp_vbit_reg <= cmp_vbit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_prof_reg <= hit_prof_next;
        free_idx_reg <= free_idx_next;
    end

    // Shared comparator: one slot per cycle, aligned with the memory read data.
    assign key_match  = cmp_vld_reg && cmp_vbit_reg && (rd_data.prof_key == item_reg.prof_key);
    assign slot_empty = cmp_vld_reg && !cmp_vbit_reg;

    // Next state and outputs.
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = scan_idx_reg;
        cmp_vbit_next = valid_reg[scan_idx_reg];
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_prof_next = hit_prof_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = hit_reg ? hit_idx_reg : free_idx_reg;

        // Keep the lowest matching slot and the lowest free slot.
        if (key_match && !hit_reg) begin
            hit_next      = 1'b1;
            hit_idx_next  = cmp_idx_reg;
            hit_prof_next = rd_data;
        end
        if (slot_empty && !free_reg) begin
            free_next     = 1'b1;
            free_idx_next = cmp_idx_reg;
        end

        unique case (state_reg)
            prt_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next     = in_item;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_idx_next = '0;
                    if (in_item.command == prt_pkg::CMD_CLEAR) begin
                        valid_next = '0;
                        state_next = prt_pkg::ST_DECIDE;
                    end else if (in_item.command == prt_pkg::CMD_SET ||
                                 in_item.command == prt_pkg::CMD_QUERY) begin
                        state_next = prt_pkg::ST_SCAN;
                    end else begin
                        state_next = prt_pkg::ST_DECIDE;
                    end
                end
            end
            prt_pkg::ST_SCAN: begin
                cmp_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = prt_pkg::ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            prt_pkg::ST_DRAIN: begin
                state_next = prt_pkg::ST_DECIDE;
            end
            prt_pkg::ST_DECIDE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = prt_pkg::ST_IDLE;
                    if (item_reg.command == prt_pkg::CMD_SET && (hit_reg || free_reg)) begin
                        wr_en               = 1'b1;
                        valid_next[wr_addr] = 1'b1;
                    end
                end
            end
            default: begin
                state_next = prt_pkg::ST_IDLE;
            end
        endcase
    end

    assign rd_addr = scan_idx_reg;

    // Profile written by a set command.
    assign wr_data.prof_key          = item_reg.prof_key;
    assign wr_data.bit_cap           = item_reg.bit_cap;
    assign wr_data.downgrade_trigger = item_reg.downgrade_trigger;
    assign wr_data.compress_trigger  = item_reg.compress_trigger;
    assign wr_data.storage_heavy     = item_reg.storage_heavy;

    // Scan outcome for the resolver.
    assign scan_res.command    = item_reg.command;
    assign scan_res.hit        = hit_reg;
    assign scan_res.free_found = free_reg;
    assign scan_res.pressure   = item_reg.pressure;
    assign scan_res.prof       = hit_prof_reg;

endmodule

`default_nettype wire

// ===== sv/prt_resolve.sv =====
// Result resolver: fallback selection, bit cap clamp and compress decision.
`default_nettype none

module prt_resolve (
    input  wire prt_pkg::prt_scan_t                 scan_res,
    input  wire logic [prt_pkg::CAP_W-1:0]          fb_bit_cap,
    input  wire logic [prt_pkg::TRIG_W-1:0]         fb_downgrade,
    input  wire logic [prt_pkg::TRIG_W-1:0]         fb_compress,
    output prt_pkg::prt_result_t                    result
);

    logic [prt_pkg::TRIG_W-1:0] base_trig;
    logic [prt_pkg::TRIG_W-1:0] heavy_trig;
    logic [prt_pkg::TRIG_W-1:0] eff_trig;

    // Stored profile's compress trigger, 0.05 lower if storage-heavy, min 0.5.
    always_comb begin
        base_trig = (scan_res.prof.compress_trigger != '0) ?
                    scan_res.prof.compress_trigger : fb_compress;
        heavy_trig = (base_trig >= prt_pkg::Q_HEAVY_LIMIT) ?
                     base_trig - prt_pkg::Q_FIVE_HUNDREDTHS : prt_pkg::Q_HALF;
        eff_trig = scan_res.prof.storage_heavy ? heavy_trig : base_trig;
    end

    // Result fields per command; fields a command leaves open are zero.
    always_comb begin
        result = '0;
        unique case (scan_res.command)
            prt_pkg::CMD_SET: begin
                result.stored = scan_res.hit || scan_res.free_found;
            end
            prt_pkg::CMD_QUERY: begin
                if (scan_res.hit) begin
                    result.found                 = 1'b1;
                    result.bit_cap_out           = prt_pkg::clamp_cap(scan_res.prof.bit_cap);
                    result.downgrade_trigger_out =
                        (scan_res.prof.downgrade_trigger != '0) ?
                        scan_res.prof.downgrade_trigger : fb_downgrade;
                    result.compress_kv           = (scan_res.pressure >= eff_trig);
                end else begin
                    result.bit_cap_out           = prt_pkg::clamp_cap(fb_bit_cap);
                    result.downgrade_trigger_out = fb_downgrade;
                    result.compress_kv           = (scan_res.pressure >= fb_compress);
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/profile_table_resolver_core.sv =====
// Top level of the profile table resolver: ports, fallback registers, result register.
//
// Input beats on s_* carry one command each: clear, set or query. A set updates
// the slot holding the same model id, else the lowest free slot, else it is
// dropped; a query resolves bit cap, downgrade trigger and compress decision.
// Every accepted beat yields exactly one result beat on m_*.
// Set and query walk all SLOT_COUNT slots through one memory read port and one
// key comparator, one slot per cycle; s_tready stays low from the accept through
// the scan, drain and decide states until the result is loaded into the output
// register. A clear, or an unused command code, skips the scan and goes straight
// to the decide state. One result waits in the output register, so the next beat
// is accepted while m_tready is low; the sequencer then holds in its final step
// until the output register drains. The fallback registers are written over
// cfg_*; the user must write them only while idle, as the block does not enforce
// it. Reset (aresetn low, synchronous) empties the table and loads the fallback
// defaults; no clearing pass is needed since slot valid bits reset at once.
`default_nettype none

module profile_table_resolver_core #(
    parameter int SLOT_COUNT = prt_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // command, model id, bit_cap, downgrade_trigger, compress_trigger,
    // storage_heavy, pressure (from bit 0 up, zero padded)
    input  wire logic [prt_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // found, stored, bit_cap_out, downgrade_trigger_out, compress_kv
    // (from bit 0 up)
    output logic [prt_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_wr_en,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [prt_pkg::TRIG_W-1:0]         cfg_wdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [prt_pkg::CAP_W-1:0]  fb_bit_cap_reg;
    logic [prt_pkg::TRIG_W-1:0] fb_downgrade_reg;
    logic [prt_pkg::TRIG_W-1:0] fb_compress_reg;
    logic                       m_valid_reg;
    prt_pkg::prt_result_t       m_data_reg;

    prt_pkg::prt_item_t    in_item;
    prt_pkg::prt_scan_t    scan_res;
    prt_pkg::prt_result_t  result;
    prt_pkg::prt_profile_t rd_data;
    prt_pkg::prt_profile_t wr_data;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_en;
    logic                  res_load;
    logic                  out_free;

    assign in_item  = prt_pkg::prt_item_t'(s_tdata[prt_pkg::ITEM_W-1:0]);
    assign out_free = !m_valid_reg || m_tready;

    // Fallback configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_bit_cap_reg   <= prt_pkg::FB_BIT_CAP_RST;
            fb_downgrade_reg <= prt_pkg::FB_DOWNGRADE_RST;
            fb_compress_reg  <= prt_pkg::FB_COMPRESS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                prt_pkg::REG_FB_BIT_CAP:   fb_bit_cap_reg   <= cfg_wdata[prt_pkg::CAP_W-1:0];
                prt_pkg::REG_FB_DOWNGRADE: fb_downgrade_reg <= cfg_wdata;
                prt_pkg::REG_FB_COMPRESS:  fb_compress_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    prt_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .res_load (res_load),
        .scan_res (scan_res),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    prt_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    prt_resolve u_resolve (
        .scan_res     (scan_res),
        .fb_bit_cap   (fb_bit_cap_reg),
        .fb_downgrade (fb_downgrade_reg),
        .fb_compress  (fb_compress_reg),
        .result       (result)
    );

    // Output register: holds one result beat until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = prt_pkg::OUT_TDATA_W'(m_data_reg);

`ifndef SYNTHESIS
    // A result is never loaded over one the receiver has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten before drain");

    // The block is busy in the cycle after it accepts a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A result never reports both a query hit and a stored profile.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_data_reg.found && m_data_reg.stored))
        else $error("found and stored both set");

    // The resolved bit cap is zero or within two through four.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_data_reg.bit_cap_out == 3'd0 || m_data_reg.bit_cap_out == 3'd2 ||
                      m_data_reg.bit_cap_out == 3'd3 || m_data_reg.bit_cap_out == 3'd4))
        else $error("bit cap out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/profile_table_resolver_core_tb.sv =====
// Self-checking testbench for the profile table resolver core.
`timescale 1ns / 1ps

// Scoreboard: mirrors the profile table and the fallback registers, predicts
// one result beat per accepted input beat and checks results in order.
class resolver_scoreboard;
    localparam int TABLE_SLOTS = prt_pkg::SLOT_COUNT_DEF;

    bit                         slot_used [TABLE_SLOTS];
    prt_pkg::prt_profile_t      slot_entry [TABLE_SLOTS];
    logic [prt_pkg::CAP_W-1:0]  fb_cap;
    logic [prt_pkg::TRIG_W-1:0] fb_downgrade;
    logic [prt_pkg::TRIG_W-1:0] fb_compress;
    prt_pkg::prt_result_t       awaited_results [$];
    int                         mismatches;

    function new();
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        fb_cap       = prt_pkg::FB_BIT_CAP_RST;
        fb_downgrade = prt_pkg::FB_DOWNGRADE_RST;
        fb_compress  = prt_pkg::FB_COMPRESS_RST;
        mismatches   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [prt_pkg::TRIG_W-1:0] val);
        case (idx)
            prt_pkg::REG_FB_BIT_CAP:   fb_cap = val[prt_pkg::CAP_W-1:0];
            prt_pkg::REG_FB_DOWNGRADE: fb_downgrade = val;
            prt_pkg::REG_FB_COMPRESS:  fb_compress = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction

    function logic [prt_pkg::CAPO_W-1:0] limit_cap(logic [prt_pkg::CAP_W-1:0] c);
        if (c < 8'd2) return 3'd2;
        if (c > 8'd4) return 3'd4;
        return c[prt_pkg::CAPO_W-1:0];
    endfunction

    // Lowest valid slot holding the key, or -1.
    function int lookup_slot(logic [prt_pkg::ID_W-1:0] id);
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (slot_used[i] && slot_entry[i].prof_key == id) return i;
        end
        return -1;
    endfunction

    // Applies one command to the mirrored table and returns its result.
    function prt_pkg::prt_result_t resolve_command(prt_pkg::prt_item_t it);
        prt_pkg::prt_result_t       r;
        int                         slot;
        logic [prt_pkg::TRIG_W-1:0] thr;
        r = '0;
        case (it.command)
            prt_pkg::CMD_CLEAR: begin
                foreach (slot_used[i]) slot_used[i] = 1'b0;
            end
            prt_pkg::CMD_SET: begin
                slot = lookup_slot(it.prof_key);
                if (slot < 0) begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (!slot_used[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot >= 0) begin
                    slot_used[slot] = 1'b1;
                    slot_entry[slot].prof_key          = it.prof_key;
                    slot_entry[slot].bit_cap           = it.bit_cap;
                    slot_entry[slot].downgrade_trigger = it.downgrade_trigger;
                    slot_entry[slot].compress_trigger  = it.compress_trigger;
                    slot_entry[slot].storage_heavy     = it.storage_heavy;
                    r.stored = 1'b1;
                end
            end
            prt_pkg::CMD_QUERY: begin
                slot = lookup_slot(it.prof_key);
                if (slot >= 0) begin
                    thr = slot_entry[slot].compress_trigger;
                    if (thr == '0) thr = fb_compress;
                    // Storage-heavy profiles compress 0.05 earlier, never below 0.5.
                    if (slot_entry[slot].storage_heavy) begin
                        thr = (thr >= prt_pkg::Q_HALF + prt_pkg::Q_FIVE_HUNDREDTHS) ?
                              thr - prt_pkg::Q_FIVE_HUNDREDTHS : prt_pkg::Q_HALF;
                    end
                    r.found = 1'b1;
                    r.bit_cap_out = limit_cap(slot_entry[slot].bit_cap);
                    r.downgrade_trigger_out = (slot_entry[slot].downgrade_trigger != '0) ?
                        slot_entry[slot].downgrade_trigger : fb_downgrade;
                    r.compress_kv = (it.pressure >= thr);
                end else begin
                    r.bit_cap_out = limit_cap(fb_cap);
                    r.downgrade_trigger_out = fb_downgrade;
                    r.compress_kv = (it.pressure >= fb_compress);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function void note_input(prt_pkg::prt_item_t it);
        awaited_results.push_back(resolve_command(it));
    endfunction

    task report(string what, prt_pkg::prt_result_t got_v, prt_pkg::prt_result_t exp_v);
        mismatches++;
        $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got_v, exp_v);
    endtask

    task check_result(prt_pkg::prt_result_t got);
        prt_pkg::prt_result_t exp;
        if (awaited_results.size() == 0) begin
            report("unexpected result beat", got, '0);
        end else begin
            exp = awaited_results.pop_front();
            if (got !== exp) report("result beat", got, exp);
        end
    endtask
endclass

module profile_table_resolver_core_tb;

    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 175;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [prt_pkg::TRIG_W-1:0] TRIG_MAX = 18'h3FFFF;
    localparam logic [prt_pkg::TRIG_W-1:0] HEAVY_EDGE =
        prt_pkg::Q_HALF + prt_pkg::Q_FIVE_HUNDREDTHS;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic [prt_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [prt_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [1:0]                      cfg_index = '0;
    logic [prt_pkg::TRIG_W-1:0]      cfg_wdata = '0;

    resolver_scoreboard sb = new();

    int                         tx_idle_pct = 33;
    int                         rx_idle_pct = 33;
    logic                       hold_req = 1'b0;
    logic [prt_pkg::ID_W-1:0]   id_base = '0;
    int                         id_span = 8;
    int                         clear_pct = 4;
    logic [prt_pkg::TRIG_W-1:0] last_compress = '0;

    always #1 aclk = ~aclk;

    profile_table_resolver_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Accepted beats on both channels feed the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(prt_pkg::prt_item_t'(s_tdata[prt_pkg::ITEM_W-1:0]));
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(prt_pkg::prt_result_t'(m_tdata[prt_pkg::RESULT_W-1:0]));
    end

    // Result side: random backpressure, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Run limit.
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic prt_pkg::prt_item_t make_item(logic [1:0] cmd,
                                                     logic [prt_pkg::ID_W-1:0] id,
                                                     logic [prt_pkg::CAP_W-1:0] cap,
                                                     logic [prt_pkg::TRIG_W-1:0] dg,
                                                     logic [prt_pkg::TRIG_W-1:0] ct,
                                                     logic heavy,
                                                     logic [prt_pkg::TRIG_W-1:0] pr);
        prt_pkg::prt_item_t it;
        it.command           = cmd;
        it.prof_key          = id;
        it.bit_cap           = cap;
        it.downgrade_trigger = dg;
        it.compress_trigger  = ct;
        it.storage_heavy     = heavy;
        it.pressure          = pr;
        return it;
    endfunction

    // Trigger values biased toward unset, full scale and the heavy floor edge.
    function automatic logic [prt_pkg::TRIG_W-1:0] pick_trigger();
        case ($urandom_range(9))
            0, 1: return '0;
            2: return TRIG_MAX;
            3: return HEAVY_EDGE;
            4: return HEAVY_EDGE - 1'b1;
            5: return prt_pkg::TRIG_W'($urandom_range(3276));
            default: return prt_pkg::TRIG_W'($urandom_range(262143));
        endcase
    endfunction

    // Pressure values placed on the thresholds the resolver compares against.
    function automatic logic [prt_pkg::TRIG_W-1:0] pick_pressure();
        case ($urandom_range(9))
            0: return '0;
            1: return TRIG_MAX;
            2: return sb.fb_compress - prt_pkg::TRIG_W'($urandom_range(1));
            3: return last_compress - prt_pkg::TRIG_W'($urandom_range(1));
            4: return last_compress - prt_pkg::Q_FIVE_HUNDREDTHS -
                      prt_pkg::TRIG_W'($urandom_range(1));
            5: return prt_pkg::Q_HALF - prt_pkg::TRIG_W'($urandom_range(1));
            default: return prt_pkg::TRIG_W'($urandom_range(262143));
        endcase
    endfunction

    function automatic logic [prt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(15) == 0) return prt_pkg::ID_W'($urandom_range(65535));
        return id_base + prt_pkg::ID_W'($urandom_range(id_span));
    endfunction

    // One random command: mostly sets and queries on the phase's key pool.
    function automatic prt_pkg::prt_item_t build_random();
        prt_pkg::prt_item_t it;
        int                 r;
        logic [1:0]         cmd;
        r = $urandom_range(99);
        if (r < clear_pct) cmd = prt_pkg::CMD_CLEAR;
        else if (r < clear_pct + 2) cmd = prt_pkg::CMD_UNUSED;
        else if (r < 50) cmd = prt_pkg::CMD_SET;
        else cmd = prt_pkg::CMD_QUERY;
        it = make_item(cmd, pick_id(),
                       ($urandom_range(1) != 0) ? prt_pkg::CAP_W'($urandom_range(7))
                                                : prt_pkg::CAP_W'($urandom_range(255)),
                       pick_trigger(), pick_trigger(), 1'($urandom_range(1)),
                       prt_pkg::TRIG_W'($urandom_range(262143)));
        if (cmd == prt_pkg::CMD_SET) last_compress = (it.compress_trigger == '0) ?
                                                     sb.fb_compress : it.compress_trigger;
        else if (cmd == prt_pkg::CMD_QUERY) it.pressure = pick_pressure();
        return it;
    endfunction

    task automatic send_item(input prt_pkg::prt_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(prt_pkg::IN_TDATA_W - prt_pkg::ITEM_W){1'b0}}, it};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    // Register write; only called while no result is outstanding.
    task automatic write_cfg(input logic [1:0] idx, input logic [prt_pkg::TRIG_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic configure_phase(input int phase);
        logic [prt_pkg::CAP_W-1:0]  cap;
        logic [prt_pkg::TRIG_W-1:0] dg;
        logic [prt_pkg::TRIG_W-1:0] ct;
        case (phase)
            1: begin cap = '0; dg = '0; ct = '0; end
            2: begin cap = 8'hFF; dg = TRIG_MAX; ct = TRIG_MAX; end
            3: begin cap = 8'd3; dg = pick_trigger(); ct = prt_pkg::FB_COMPRESS_RST; end
            default: begin
                cap = ($urandom_range(3) == 0) ? 8'hFF : prt_pkg::CAP_W'($urandom_range(6));
                dg  = pick_trigger();
                ct  = pick_trigger();
            end
        endcase
        write_cfg(prt_pkg::REG_FB_BIT_CAP, prt_pkg::TRIG_W'(cap));
        write_cfg(prt_pkg::REG_FB_DOWNGRADE, dg);
        write_cfg(prt_pkg::REG_FB_COMPRESS, ct);
    endtask

    initial begin
        int spans [PHASES];
        spans = '{12, 5, 40, 100, 200, 70, 8, 150, 30, 1000};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, field extremes, heavy floor edges, upsert,
        // unset triggers, the unused command and clear.
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h0000, '0, '0, '0, 1'b0,
                            prt_pkg::FB_COMPRESS_RST));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'hFFFF, '0, '0, '0, 1'b0,
                            prt_pkg::FB_COMPRESS_RST - 1'b1));
        send_item(make_item(prt_pkg::CMD_SET, 16'h0000, 8'd0, '0, '0, 1'b0, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h0000, '0, '0, '0, 1'b0, '0));
        send_item(make_item(prt_pkg::CMD_SET, 16'hFFFF, 8'hFF, TRIG_MAX, TRIG_MAX, 1'b1, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'hFFFF, 8'hFF, TRIG_MAX, TRIG_MAX, 1'b1,
                            TRIG_MAX));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'hFFFF, '0, '0, '0, 1'b0,
                            TRIG_MAX - prt_pkg::Q_FIVE_HUNDREDTHS - 1'b1));
        send_item(make_item(prt_pkg::CMD_SET, 16'h1234, 8'd3, 18'd1, HEAVY_EDGE, 1'b1, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1234, '0, '0, '0, 1'b0, prt_pkg::Q_HALF));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1234, '0, '0, '0, 1'b0,
                            prt_pkg::Q_HALF - 1'b1));
        send_item(make_item(prt_pkg::CMD_SET, 16'h1235, 8'd4, 18'd7, HEAVY_EDGE - 1'b1,
                            1'b1, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1235, '0, '0, '0, 1'b0, prt_pkg::Q_HALF));
        send_item(make_item(prt_pkg::CMD_SET, 16'h1236, 8'd5, '0, 18'd100, 1'b1, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1236, '0, '0, '0, 1'b0,
                            prt_pkg::Q_HALF - 1'b1));
        send_item(make_item(prt_pkg::CMD_SET, 16'h1237, 8'd1, '0, '0, 1'b1, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1237, '0, '0, '0, 1'b0,
                            prt_pkg::FB_COMPRESS_RST - prt_pkg::Q_FIVE_HUNDREDTHS));
        send_item(make_item(prt_pkg::CMD_SET, 16'h0000, 8'd2, 18'd5, 18'd1, 1'b0, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h0000, '0, '0, '0, 1'b0, 18'd1));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h0000, '0, '0, '0, 1'b0, '0));
        send_item(make_item(prt_pkg::CMD_UNUSED, 16'hFFFF, 8'hFF, TRIG_MAX, TRIG_MAX, 1'b1,
                            TRIG_MAX));
        send_item(make_item(prt_pkg::CMD_CLEAR, 16'h1234, '0, '0, '0, 1'b0, '0));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'h1234, '0, '0, '0, 1'b0, TRIG_MAX));
        send_item(make_item(prt_pkg::CMD_QUERY, 16'hFFFF, '0, '0, '0, 1'b0, '0));
        wait_for_results();

        // Random phases, each under its own fallback setting and key pool.
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) configure_phase(phase);
            id_base     = prt_pkg::ID_W'($urandom_range(65535));
            id_span     = spans[phase];
            clear_pct   = (id_span > 64) ? 1 : 4;
            tx_idle_pct = (phase == 3) ? 0 : 33;
            rx_idle_pct = (phase == 3) ? 0 : 33;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver hold-off while input keeps coming.
                if (phase == 4 && n == 40) hold_req <= 1'b1;
                // Sender pause until the block has drained.
                if (phase == 6 && n == 90) wait_for_results();
                send_item(build_random());
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/prt_pkg.sv
sv/prt_store.sv
sv/prt_ctrl.sv
sv/prt_resolve.sv
sv/profile_table_resolver_core.sv
tb/sv/profile_table_resolver_core_tb.sv
